### hdl/cst_pkg.sv
// Shared types, constants and keyword tables for the C subset tokenizer.
// Used by the controller, the datapath and the top level; depends on nothing.
package cst_pkg;

	localparam int MAX_TOKEN_LEN_DEF = 32;

	localparam int CHAR_W = 8;
	localparam int KIND_W = 5;
	localparam int IDX_W  = 5;
	localparam int NUM_KW = 5;

	localparam logic [KIND_W-1:0] K_ADDSUB   = 5'd0;
	localparam logic [KIND_W-1:0] K_MULDIV   = 5'd1;
	localparam logic [KIND_W-1:0] K_COMPARE  = 5'd2;
	localparam logic [KIND_W-1:0] K_ASSIGN   = 5'd3;
	localparam logic [KIND_W-1:0] K_COMMA    = 5'd4;
	localparam logic [KIND_W-1:0] K_SEMI     = 5'd5;
	localparam logic [KIND_W-1:0] K_LPAREN   = 5'd6;
	localparam logic [KIND_W-1:0] K_RPAREN   = 5'd7;
	localparam logic [KIND_W-1:0] K_LBRACE   = 5'd8;
	localparam logic [KIND_W-1:0] K_RBRACE   = 5'd9;
	localparam logic [KIND_W-1:0] K_KW_FIRST = 5'd10;
	localparam logic [KIND_W-1:0] K_NUMBER   = 5'd15;
	localparam logic [KIND_W-1:0] K_IDENT    = 5'd16;
	localparam logic [KIND_W-1:0] K_INVALID  = 5'd17;
	localparam logic [KIND_W-1:0] K_BANG     = 5'd18;
	localparam logic [KIND_W-1:0] K_LONG     = 5'd19;
	localparam logic [KIND_W-1:0] K_END      = 5'd20;

	localparam logic [2:0] KW_IF     = 3'd0;
	localparam logic [2:0] KW_ELSE   = 3'd1;
	localparam logic [2:0] KW_WHILE  = 3'd2;
	localparam logic [2:0] KW_RETURN = 3'd3;
	localparam logic [2:0] KW_INT    = 3'd4;

	// Source of the item loaded into the output register.
	typedef enum logic [2:0] {
		SRC_FLUSH = 3'd0,
		SRC_PRE0  = 3'd1,
		SRC_PRE1  = 3'd2,
		SRC_TAIL  = 3'd3,
		SRC_END   = 3'd4
	} emit_src_t;

	typedef struct packed {
		logic      accept;    // capture the input item
		logic      idx_clr;   // rewind the flush index
		logic      rd_en;     // read the word buffer
		logic      rd_next;   // read index+1 and advance the index
		logic      emit;      // load the output register
		emit_src_t src;
		logic      tail_upd;  // apply the scan state update for this byte
		logic      end_upd;   // return to idle after end of input
	} cmd_t;

	typedef struct packed {
		logic       flush_go;   // a collected word must be emitted
		logic       flush_last; // the flush index is on the last character
		logic [1:0] pre_cnt;    // operator results ahead of the tail
		logic       eoi;
		logic       tail_emit;  // the tail update emits an item
		logic       out_free;   // the output register can take an item now
	} status_t;

	function automatic logic [2:0] kw_len(input logic [2:0] k);
		case (k)
			KW_IF:     return 3'd2;
			KW_ELSE:   return 3'd4;
			KW_WHILE:  return 3'd5;
			KW_RETURN: return 3'd6;
			KW_INT:    return 3'd3;
			default:   return 3'd0;
		endcase
	endfunction

	function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] p);
		logic [47:0] s;
		case (k)
			KW_IF:     s = {"if", 32'h0};
			KW_ELSE:   s = {"else", 16'h0};
			KW_WHILE:  s = {"while", 8'h0};
			KW_RETURN: s = "return";
			KW_INT:    s = {"int", 24'h0};
			default:   s = '0;
		endcase
		case (p)
			3'd0:    return s[47:40];
			3'd1:    return s[39:32];
			3'd2:    return s[31:24];
			3'd3:    return s[23:16];
			3'd4:    return s[15:8];
			3'd5:    return s[7:0];
			default: return 8'h00;
		endcase
	endfunction

endpackage

### hdl/cst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hdl/cst_ctrl.sv
// Controller of the tokenizer: sequences word flush, operator results, the scan
// update and the end marker for each item. Depends on cst_pkg.
module cst_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             src_valid,
	output logic             src_stall,
	input  cst_pkg::status_t st,
	output cst_pkg::cmd_t    cmd
);
	import cst_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_EVAL   = 8'b0000_0010,
		ST_FL_RD  = 8'b0000_0100,
		ST_FL_OUT = 8'b0000_1000,
		ST_PRE0   = 8'b0001_0000,
		ST_PRE1   = 8'b0010_0000,
		ST_TAIL   = 8'b0100_0000,
		ST_END    = 8'b1000_0000
	} state_t;

	state_t state_q, state_n;
	state_t after_pre;
	state_t after_flush;

	always_comb begin
		after_pre   = st.eoi ? ST_END : ST_TAIL;
		after_flush = (st.pre_cnt != 2'd0) ? ST_PRE0 : after_pre;
	end

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		cmd.src = SRC_END;
		case (state_q)
			ST_IDLE: begin
				cmd.accept = src_valid;
				if (src_valid) state_n = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.idx_clr = 1'b1;
				state_n = st.flush_go ? ST_FL_RD : after_flush;
			end
			ST_FL_RD: begin
				cmd.rd_en = 1'b1;
				state_n = ST_FL_OUT;
			end
			ST_FL_OUT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.src  = SRC_FLUSH;
					if (st.flush_last) begin
						state_n = after_flush;
					end else begin
						// fetch the next character while this one goes out
						cmd.rd_en   = 1'b1;
						cmd.rd_next = 1'b1;
					end
				end
			end
			ST_PRE0: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.src  = SRC_PRE0;
					state_n  = (st.pre_cnt == 2'd2) ? ST_PRE1 : after_pre;
				end
			end
			ST_PRE1: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.src  = SRC_PRE1;
					state_n  = after_pre;
				end
			end
			ST_TAIL: begin
				if (!st.tail_emit || st.out_free) begin
					cmd.tail_upd = 1'b1;
					cmd.emit     = st.tail_emit;
					cmd.src      = SRC_TAIL;
					state_n      = ST_IDLE;
				end
			end
			ST_END: begin
				if (st.out_free) begin
					cmd.emit    = 1'b1;
					cmd.src     = SRC_END;
					cmd.end_upd = 1'b1;
					state_n     = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	assign src_stall = (state_q != ST_IDLE);

	a_next_not_past_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_next |-> !st.flush_last)
		else $error("flush read beyond the word");

	a_flush_has_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FL_RD) |=> (state_q == ST_FL_OUT))
		else $error("flush read not followed by output");

	a_tail_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tail_upd |=> (state_q == ST_IDLE) && !cmd.tail_upd)
		else $error("scan update not followed by idle");

endmodule

### hdl/cst_dp.sv
// Datapath of the tokenizer: scan state, keyword match flags, word buffer RAM
// and the output register. Depends on cst_pkg and cst_ram.
module cst_dp #(
	parameter int MAX_TOKEN_LEN = cst_pkg::MAX_TOKEN_LEN_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [cst_pkg::CHAR_W-1:0] in_char,
	input  logic                       end_of_input,
	input  cst_pkg::cmd_t              cmd,
	output cst_pkg::status_t           st,
	input  logic                       tok_stall,
	output logic                       tok_valid,
	output logic [cst_pkg::CHAR_W-1:0] token_char,
	output logic [cst_pkg::KIND_W-1:0] token_kind,
	output logic [cst_pkg::IDX_W-1:0]  char_index,
	output logic                       last
);
	import cst_pkg::*;

	localparam int WORD_LIMIT = ((MAX_TOKEN_LEN - 1) < 31) ? (MAX_TOKEN_LEN - 1) : 31;
	localparam int AW = $clog2(WORD_LIMIT);
	localparam int LW = $clog2(WORD_LIMIT + 1);

	localparam logic [7:0] CH_SLASH = "/";
	localparam logic [7:0] CH_STAR  = "*";
	localparam logic [7:0] CH_EQ    = "=";
	localparam logic [7:0] CH_BANG  = "!";
	localparam logic [7:0] CH_LT    = "<";
	localparam logic [7:0] CH_GT    = ">";
	localparam logic [7:0] CH_PLUS  = "+";
	localparam logic [7:0] CH_MINUS = "-";
	localparam logic [7:0] CH_PCT   = "%";
	localparam logic [7:0] CH_COMMA = ",";
	localparam logic [7:0] CH_SEMI  = ";";
	localparam logic [7:0] CH_LPAR  = "(";
	localparam logic [7:0] CH_RPAR  = ")";
	localparam logic [7:0] CH_LBR   = "{";
	localparam logic [7:0] CH_RBR   = "}";
	localparam logic [7:0] CH_UNDER = "_";
	localparam logic [7:0] CH_NL    = 8'h0A;

	typedef enum logic [7:0] {
		M_IDLE   = 8'b0000_0001,
		M_NUMBER = 8'b0000_0010,
		M_IDENT  = 8'b0000_0100,
		M_HELD   = 8'b0000_1000,
		M_SLASH  = 8'b0001_0000,
		M_LINE   = 8'b0010_0000,
		M_BLOCK  = 8'b0100_0000,
		M_STAR   = 8'b1000_0000
	} mode_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
	endfunction

	mode_t             mode_q, mode_n;
	logic [7:0]        held_q, held_n;
	logic [LW-1:0]     len_q, len_n;
	logic              ovf_q, ovf_n;
	logic [NUM_KW-1:0] kw_q, kw_n;
	logic [7:0]        char_q;
	logic              eoi_q;
	logic [AW-1:0]     idx_q;

	logic              tok_valid_q;
	logic [7:0]        tok_char_q;
	logic [KIND_W-1:0] tok_kind_q;
	logic [IDX_W-1:0]  tok_idx_q;
	logic              tok_last_q;

	logic              out_free;
	logic              flush_last;
	logic [KIND_W-1:0] word_kind;
	logic [7:0]        rdata;
	logic [AW-1:0]     raddr;

	logic              we;
	logic [AW-1:0]     waddr;
	logic              t_emit;
	logic [7:0]        t_char;
	logic [KIND_W-1:0] t_kind;
	logic              do_app;
	logic              do_start;
	logic [NUM_KW-1:0] kw_base;
	logic [LW-1:0]     kw_pos;

	logic [7:0]        e_char;
	logic [KIND_W-1:0] e_kind;
	logic [IDX_W-1:0]  e_idx;
	logic              e_last;

	logic [7:0]        p0_char;
	logic [KIND_W-1:0] p0_kind;
	logic              p0_last;
	logic              held_pair;
	logic              word_mode;
	logic              word_cont;
	logic [1:0]        pre_cnt;

	// Capture the item.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			char_q <= in_char;
			eoi_q  <= end_of_input;
		end
	end

	// Flush index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.rd_next) begin
			idx_q <= idx_q + AW'(1);
		end
	end

	assign raddr = cmd.rd_next ? (idx_q + AW'(1)) : idx_q;

	// Write the buffer only with the scan update, after any flush has read it.
	cst_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(WORD_LIMIT)
	) u_word_buf (
		.clk   (clk),
		.we    (we && cmd.tail_upd),
		.waddr (waddr),
		.wdata (char_q),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign word_mode  = (mode_q == M_NUMBER) || (mode_q == M_IDENT);
	assign word_cont  = ((mode_q == M_NUMBER) && is_digit(char_q)) ||
		((mode_q == M_IDENT) &&
		(is_alpha(char_q) || is_digit(char_q) || (char_q == CH_UNDER)));
	assign flush_last = ((LW'(idx_q) + LW'(1)) == len_q);
	assign held_pair  = (mode_q == M_HELD) && !eoi_q && (char_q == CH_EQ);

	// Kind of the collected word; keywords are tracked as the word is built.
	always_comb begin
		word_kind = (mode_q == M_IDENT) ? K_IDENT : K_NUMBER;
		if (mode_q == M_IDENT) begin
			for (int i = 0; i < NUM_KW; i++) begin
				if (kw_q[i] && (len_q == LW'(kw_len(3'(i))))) begin
					word_kind = KIND_W'(K_KW_FIRST + i);
				end
			end
		end
	end

	// Held operator or slash results that come before the tail.
	always_comb begin
		p0_char = held_q;
		p0_last = 1'b1;
		if (mode_q == M_SLASH) begin
			p0_char = CH_SLASH;
			p0_kind = K_MULDIV;
		end else if (held_pair) begin
			p0_kind = K_COMPARE;
			p0_last = 1'b0;
		end else if (held_q == CH_EQ) begin
			p0_kind = K_ASSIGN;
		end else if (held_q == CH_BANG) begin
			p0_kind = K_BANG;
		end else begin
			p0_kind = K_COMPARE;
		end
	end

	always_comb begin
		pre_cnt = 2'd0;
		if (mode_q == M_HELD) begin
			pre_cnt = held_pair ? 2'd2 : 2'd1;
		end else if (mode_q == M_SLASH) begin
			if (eoi_q || ((char_q != CH_SLASH) && (char_q != CH_STAR))) begin
				pre_cnt = 2'd1;
			end
		end
	end

	// Scan state update for the current byte (not end of input).
	always_comb begin
		mode_n   = mode_q;
		held_n   = held_q;
		len_n    = len_q;
		ovf_n    = ovf_q;
		kw_n     = kw_q;
		we       = 1'b0;
		waddr    = len_q[AW-1:0];
		t_emit   = 1'b0;
		t_char   = char_q;
		t_kind   = K_INVALID;
		do_app   = 1'b0;
		do_start = 1'b0;
		kw_base  = kw_q;
		kw_pos   = len_q;
		case (mode_q)
			M_NUMBER, M_IDENT: begin
				if (word_cont) do_app = 1'b1;
				else do_start = 1'b1;
			end
			M_HELD: begin
				if (char_q == CH_EQ) begin
					mode_n = M_IDLE;
					held_n = 8'h00;
				end else begin
					do_start = 1'b1;
				end
			end
			M_SLASH: begin
				if (char_q == CH_SLASH) mode_n = M_LINE;
				else if (char_q == CH_STAR) mode_n = M_BLOCK;
				else do_start = 1'b1;
			end
			M_LINE: begin
				if (char_q == CH_NL) mode_n = M_IDLE;
			end
			M_BLOCK: begin
				if (char_q == CH_STAR) mode_n = M_STAR;
			end
			M_STAR: begin
				if (char_q == CH_SLASH) mode_n = M_IDLE;
				else if (char_q != CH_STAR) mode_n = M_BLOCK;
			end
			default: begin
				do_start = 1'b1;
			end
		endcase

		if (do_start) begin
			mode_n  = M_IDLE;
			held_n  = 8'h00;
			len_n   = '0;
			ovf_n   = 1'b0;
			kw_base = '1;
			kw_pos  = '0;
			if (is_space(char_q)) begin
				mode_n = M_IDLE;
			end else if (char_q == CH_SLASH) begin
				mode_n = M_SLASH;
			end else if ((char_q == CH_EQ) || (char_q == CH_BANG) ||
				(char_q == CH_LT) || (char_q == CH_GT)) begin
				held_n = char_q;
				mode_n = M_HELD;
			end else if ((char_q == CH_PLUS) || (char_q == CH_MINUS)) begin
				t_emit = 1'b1;
				t_kind = K_ADDSUB;
			end else if ((char_q == CH_STAR) || (char_q == CH_PCT)) begin
				t_emit = 1'b1;
				t_kind = K_MULDIV;
			end else if (char_q == CH_COMMA) begin
				t_emit = 1'b1;
				t_kind = K_COMMA;
			end else if (char_q == CH_SEMI) begin
				t_emit = 1'b1;
				t_kind = K_SEMI;
			end else if (char_q == CH_LPAR) begin
				t_emit = 1'b1;
				t_kind = K_LPAREN;
			end else if (char_q == CH_RPAR) begin
				t_emit = 1'b1;
				t_kind = K_RPAREN;
			end else if (char_q == CH_LBR) begin
				t_emit = 1'b1;
				t_kind = K_LBRACE;
			end else if (char_q == CH_RBR) begin
				t_emit = 1'b1;
				t_kind = K_RBRACE;
			end else if (is_digit(char_q)) begin
				mode_n = M_NUMBER;
				do_app = 1'b1;
			end else if (is_alpha(char_q) || (char_q == CH_UNDER)) begin
				mode_n = M_IDENT;
				do_app = 1'b1;
			end else begin
				t_emit = 1'b1;
				t_kind = K_INVALID;
			end
		end

		if (do_app) begin
			if (do_start || !ovf_q) begin
				if (kw_pos < LW'(WORD_LIMIT)) begin
					we    = 1'b1;
					waddr = kw_pos[AW-1:0];
					len_n = kw_pos + LW'(1);
					for (int i = 0; i < NUM_KW; i++) begin
						kw_n[i] = kw_base[i] && (kw_pos < LW'(kw_len(3'(i)))) &&
							(char_q == kw_char(3'(i), kw_pos[2:0]));
					end
				end else begin
					// drop the word and report it once
					ovf_n  = 1'b1;
					t_emit = 1'b1;
					t_char = 8'h00;
					t_kind = K_LONG;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			held_q <= 8'h00;
			len_q  <= '0;
			ovf_q  <= 1'b0;
			kw_q   <= '0;
		end else if (cmd.end_upd) begin
			mode_q <= M_IDLE;
			held_q <= 8'h00;
			len_q  <= '0;
			ovf_q  <= 1'b0;
			kw_q   <= '0;
		end else if (cmd.tail_upd) begin
			mode_q <= mode_n;
			held_q <= held_n;
			len_q  <= len_n;
			ovf_q  <= ovf_n;
			kw_q   <= kw_n;
		end
	end

	// Output register.
	always_comb begin
		case (cmd.src)
			SRC_FLUSH: begin
				e_char = rdata;
				e_kind = word_kind;
				e_idx  = IDX_W'(idx_q);
				e_last = flush_last;
			end
			SRC_PRE0: begin
				e_char = p0_char;
				e_kind = p0_kind;
				e_idx  = '0;
				e_last = p0_last;
			end
			SRC_PRE1: begin
				e_char = CH_EQ;
				e_kind = K_COMPARE;
				e_idx  = IDX_W'(1);
				e_last = 1'b1;
			end
			SRC_TAIL: begin
				e_char = t_char;
				e_kind = t_kind;
				e_idx  = '0;
				e_last = 1'b1;
			end
			default: begin
				e_char = 8'h00;
				e_kind = K_END;
				e_idx  = '0;
				e_last = 1'b1;
			end
		endcase
	end

	assign out_free = !tok_valid_q || !tok_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			tok_valid_q <= 1'b1;
		end else if (!tok_stall) begin
			tok_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			tok_char_q <= e_char;
			tok_kind_q <= e_kind;
			tok_idx_q  <= e_idx;
			tok_last_q <= e_last;
		end
	end

	assign tok_valid  = tok_valid_q;
	assign token_char = tok_char_q;
	assign token_kind = tok_kind_q;
	assign char_index = tok_idx_q;
	assign last       = tok_last_q;

	always_comb begin
		st.flush_go   = word_mode && !ovf_q && (len_q != '0) && (eoi_q || !word_cont);
		st.flush_last = flush_last;
		st.pre_cnt    = pre_cnt;
		st.eoi        = eoi_q;
		st.tail_emit  = t_emit;
		st.out_free   = out_free;
	end

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(WORD_LIMIT))
		else $error("word length past the limit");

	a_held_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == M_HELD) == (held_q != 8'h00))
		else $error("held operator out of step with scan mode");

	a_ovf_word: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> ((mode_q == M_NUMBER) || (mode_q == M_IDENT)))
		else $error("overflow flag outside a word");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("item loaded over a waiting item");

endmodule

### hdl/c_subset_tokenizer_top.sv
// Top level of the C subset tokenizer: controller and datapath.
// Depends on cst_pkg, cst_ctrl, cst_dp (and cst_ram through cst_dp).
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  source  | src_valid, src_stall | in_char, end_of_input
//  token   | tok_valid, tok_stall | token_char, token_kind, char_index, last
//
// A byte that emits nothing or one item passes capture, decode and scan update.
// Closing a word first reads one character ahead from the word buffer RAM, then
// sends one character per cycle while the output register is free; each held
// operator or slash item adds a step. An output stall holds the emitting steps.
// The source is stalled while an item is in work; reset returns to idle.
module c_subset_tokenizer_top #(
	parameter int MAX_TOKEN_LEN = cst_pkg::MAX_TOKEN_LEN_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       src_valid,
	output logic                       src_stall,
	input  logic [cst_pkg::CHAR_W-1:0] in_char,
	input  logic                       end_of_input,
	output logic                       tok_valid,
	input  logic                       tok_stall,
	output logic [cst_pkg::CHAR_W-1:0] token_char,
	output logic [cst_pkg::KIND_W-1:0] token_kind,
	output logic [cst_pkg::IDX_W-1:0]  char_index,
	output logic                       last
);
	import cst_pkg::*;

	cmd_t    cmd;
	status_t st;

	cst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.st        (st),
		.cmd       (cmd)
	);

	cst_dp #(
		.MAX_TOKEN_LEN(MAX_TOKEN_LEN)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_char      (in_char),
		.end_of_input (end_of_input),
		.cmd          (cmd),
		.st           (st),
		.tok_stall    (tok_stall),
		.tok_valid    (tok_valid),
		.token_char   (token_char),
		.token_kind   (token_kind),
		.char_index   (char_index),
		.last         (last)
	);

endmodule

### tb/c_subset_tokenizer_top_test.sv
// Self-checking testbench for c_subset_tokenizer_top: a directed stimulus table, then random
// C-like source text, with every token item checked against an in-bench lexer model.
// Depends on cst_pkg and the tokenizer RTL under hdl/.
`timescale 1ns / 1ps

module c_subset_tokenizer_top_test;
	import cst_pkg::*;

	localparam int WORD_MAX     = (MAX_TOKEN_LEN_DEF - 1 < 31) ? MAX_TOKEN_LEN_DEF - 1 : 31;
	localparam int RANDOM_ITEMS = 290;
	localparam int CALM_TAIL    = 80;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 100;
	localparam int QUIET_LIMIT  = 2000;
	localparam int N_DIR        = 31;

	typedef enum logic [2:0] {
		SC_IDLE, SC_NUMBER, SC_IDENT, SC_HELD, SC_SLASH, SC_LINE, SC_BLOCK, SC_STAR
	} scan_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0]  idx;
		logic              lst;
	} tok_t;

	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic              eoi;
		bit                typed;
		tok_t              exp;
	} src_item_t;

	typedef struct {
		string             text;   // bytes sent in order; empty sends raw
		logic [CHAR_W-1:0] raw;
		int                reps;
		logic              eoi;
		bit                typed;
		tok_t              exp;
	} dir_row_t;

	localparam tok_t NO_TOK = '0;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              src_valid;
	logic              src_stall;
	logic [CHAR_W-1:0] in_char;
	logic              end_of_input;
	logic              tok_valid;
	logic              tok_stall;
	logic [CHAR_W-1:0] token_char;
	logic [KIND_W-1:0] token_kind;
	logic [IDX_W-1:0]  char_index;
	logic              last;

	c_subset_tokenizer_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.src_valid    (src_valid),
		.src_stall    (src_stall),
		.in_char      (in_char),
		.end_of_input (end_of_input),
		.tok_valid    (tok_valid),
		.tok_stall    (tok_stall),
		.token_char   (token_char),
		.token_kind   (token_kind),
		.char_index   (char_index),
		.last         (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Lexer model state
	logic [CHAR_W-1:0] word_buf [32];
	int                word_len = 0;
	scan_t             scan     = SC_IDLE;
	logic [CHAR_W-1:0] held_op  = '0;
	bit                word_ovf = 1'b0;

	tok_t      step_tokens[$];
	tok_t      pending_tokens[$];
	src_item_t source_items[$];

	string kw_names [5]  = '{"if", "else", "while", "return", "int"};
	string op_names [19] = '{"+", "-", "*", "/", "%", "=", "==", "!=", "<", "<=", ">", ">=",
		"!", ",", ";", "(", ")", "{", "}"};

	int n_errors    = 0;
	int n_counted   = 0;
	int quiet_cycles = 0;
	bit hold_start  = 1'b0;
	bit idle_src    = 1'b0;
	bit idle_rx     = 1'b0;

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_space(logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic void emit(logic [7:0] ch, logic [4:0] kind, int idx, logic lst);
		tok_t t;
		t.ch   = ch;
		t.kind = kind;
		t.idx  = IDX_W'(idx);
		t.lst  = lst;
		step_tokens.push_back(t);
	endfunction

	function automatic void word_flush();
		logic [4:0] kind;
		bit         same;
		kind = (scan == SC_IDENT) ? K_IDENT : K_NUMBER;
		if (!word_ovf && word_len > 0) begin
			if (kind == K_IDENT) begin
				for (int k = 0; k < 5; k++) begin
					if (kw_names[k].len() == word_len) begin
						same = 1'b1;
						for (int i = 0; i < word_len; i++)
							if (kw_names[k][i] != word_buf[i]) same = 1'b0;
						if (same) kind = K_KW_FIRST + 5'(k);
					end
				end
			end
			for (int i = 0; i < word_len; i++)
				emit(word_buf[i], kind, i, i + 1 == word_len);
		end
		word_len = 0;
		word_ovf = 1'b0;
		scan     = SC_IDLE;
	endfunction

	function automatic void word_add(logic [7:0] c);
		if (word_ovf) return;
		if (word_len < WORD_MAX) begin
			word_buf[word_len] = c;
			word_len++;
		end else begin
			// first character past the limit: report once, drop the rest of the word
			word_ovf = 1'b1;
			emit(8'h00, K_LONG, 0, 1'b1);
		end
	endfunction

	function automatic void held_resolve();
		if (held_op == "=") emit("=", K_ASSIGN, 0, 1'b1);
		else if (held_op == "!") emit("!", K_BANG, 0, 1'b1);
		else emit(held_op, K_COMPARE, 0, 1'b1);
		held_op = '0;
		scan    = SC_IDLE;
	endfunction

	function automatic void lex_start(logic [7:0] c);
		scan = SC_IDLE;
		if (is_space(c)) begin
		end else if (c == "/") begin
			scan = SC_SLASH;
		end else if (c inside {"=", "!", "<", ">"}) begin
			held_op = c;
			scan    = SC_HELD;
		end else if (c == "+" || c == "-") begin
			emit(c, K_ADDSUB, 0, 1'b1);
		end else if (c == "*" || c == "%") begin
			emit(c, K_MULDIV, 0, 1'b1);
		end else if (c == ",") begin
			emit(c, K_COMMA, 0, 1'b1);
		end else if (c == ";") begin
			emit(c, K_SEMI, 0, 1'b1);
		end else if (c == "(") begin
			emit(c, K_LPAREN, 0, 1'b1);
		end else if (c == ")") begin
			emit(c, K_RPAREN, 0, 1'b1);
		end else if (c == "{") begin
			emit(c, K_LBRACE, 0, 1'b1);
		end else if (c == "}") begin
			emit(c, K_RBRACE, 0, 1'b1);
		end else if (is_digit(c)) begin
			scan = SC_NUMBER;
			word_add(c);
		end else if (is_alpha(c) || c == "_") begin
			scan = SC_IDENT;
			word_add(c);
		end else begin
			emit(c, K_INVALID, 0, 1'b1);
		end
	endfunction

	function automatic void lex_step(logic [7:0] c, logic eoi);
		if (eoi) begin
			if (scan == SC_NUMBER || scan == SC_IDENT) word_flush();
			else if (scan == SC_HELD) held_resolve();
			else if (scan == SC_SLASH) emit("/", K_MULDIV, 0, 1'b1);
			emit(8'h00, K_END, 0, 1'b1);
			word_len = 0;
			word_ovf = 1'b0;
			held_op  = '0;
			scan     = SC_IDLE;
			return;
		end
		case (scan)
			SC_NUMBER: begin
				if (is_digit(c)) word_add(c);
				else begin
					word_flush();
					lex_start(c);
				end
			end
			SC_IDENT: begin
				if (is_alpha(c) || is_digit(c) || c == "_") word_add(c);
				else begin
					word_flush();
					lex_start(c);
				end
			end
			SC_HELD: begin
				if (c == "=") begin
					emit(held_op, K_COMPARE, 0, 1'b0);
					emit("=", K_COMPARE, 1, 1'b1);
					held_op = '0;
					scan    = SC_IDLE;
				end else begin
					held_resolve();
					lex_start(c);
				end
			end
			SC_SLASH: begin
				if (c == "/") scan = SC_LINE;
				else if (c == "*") scan = SC_BLOCK;
				else begin
					emit("/", K_MULDIV, 0, 1'b1);
					lex_start(c);
				end
			end
			SC_LINE:  if (c == 8'h0A) scan = SC_IDLE;
			SC_BLOCK: if (c == "*") scan = SC_STAR;
			SC_STAR: begin
				if (c == "/") scan = SC_IDLE;
				else if (c != "*") scan = SC_BLOCK;
			end
			default: lex_start(c);
		endcase
	endfunction

	// Advance the model on an accepted item and queue what it should produce.
	function automatic void lex_accept(src_item_t it);
		step_tokens.delete();
		lex_step(it.ch, it.eoi);
		if (it.typed) pending_tokens.push_back(it.exp);
		else foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
	endfunction

	function automatic void add_byte(logic [7:0] c, bit counted);
		src_item_t it;
		it.ch    = c;
		it.eoi   = 1'b0;
		it.typed = 1'b0;
		it.exp   = NO_TOK;
		source_items.push_back(it);
		if (counted) n_counted++;
	endfunction

	function automatic void add_text(string s);
		for (int j = 0; j < s.len(); j++) add_byte(s[j], 1'b1);
	endfunction

	function automatic void add_eoi();
		src_item_t it;
		it.ch    = 8'($urandom_range(0, 255));
		it.eoi   = 1'b1;
		it.typed = 1'b0;
		it.exp   = NO_TOK;
		source_items.push_back(it);
		n_counted++;
	endfunction

	function automatic logic [7:0] ident_char(bit first);
		int r;
		r = $urandom_range(0, first ? 52 : 62);
		if (r < 26) return 8'("a" + r);
		if (r < 52) return 8'("A" + r - 26);
		if (r == 52) return "_";
		return 8'("0" + r - 53);
	endfunction

	function automatic void add_fragment();
		string marks;
		int    sel;
		int    len;
		int    r;
		marks = "*/ a\n";
		sel = $urandom_range(0, 99);
		if (sel < 18) begin
			add_text(kw_names[$urandom_range(0, 4)]);
		end else if (sel < 34) begin
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 8);
			add_byte(ident_char(1'b1), 1'b1);
			for (int j = 1; j < len; j++) add_byte(ident_char(1'b0), 1'b1);
		end else if (sel < 44) begin
			len = $urandom_range(1, 6);
			for (int j = 0; j < len; j++) add_byte(8'("0" + $urandom_range(0, 9)), 1'b1);
		end else if (sel < 64) begin
			add_text(op_names[$urandom_range(0, 18)]);
		end else if (sel < 74) begin
			r = $urandom_range(8, 13);
			add_byte((r == 8) ? " " : 8'(r), 1'b1);
		end else if (sel < 80) begin
			add_text("//");
			len = $urandom_range(0, 10);
			for (int j = 0; j < len; j++) add_byte(8'($urandom_range(32, 126)), 1'b1);
			if ($urandom_range(0, 4) != 0) add_byte(8'h0A, 1'b1);
		end else if (sel < 86) begin
			add_text("/*");
			len = $urandom_range(0, 8);
			for (int j = 0; j < len; j++) add_byte(marks[$urandom_range(0, 4)], 1'b1);
			add_text("*/");
		end else if (sel < 98) begin
			add_byte(8'($urandom_range(0, 255)), 1'b1);
		end else begin
			add_eoi();
		end
		// separate words half of the time; otherwise let them run together
		if (sel < 44 && $urandom_range(0, 1) == 1) add_byte(" ", 1'b1);
	endfunction

	task automatic report(input string msg);
		if (n_errors < 50) $display("MISMATCH at %0t: %s", $time, msg);
		n_errors++;
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_item(src_item_t it);
		int gap;
		if (idle_src && $urandom_range(0, 3) == 0) begin
			src_valid <= 1'b0;
			gap = $urandom_range(1, 5);
			repeat (gap) @(negedge clk);
		end
		src_valid    <= 1'b1;
		in_char      <= it.ch;
		end_of_input <= it.eoi;
		@(posedge clk);
		while (src_stall) @(posedge clk);
		lex_accept(it);
		@(negedge clk);
	endtask

	initial begin : source_side
		dir_row_t  dir_table [N_DIR];
		src_item_t it;
		int        n_dir;
		int        n_items;
		int        n_last;
		dir_table = '{
			'{"", 8'h00, 1, 1'b0, 1'b1, '{8'h00, K_INVALID, 5'd0, 1'b1}},
			'{"", 8'hFF, 1, 1'b0, 1'b1, '{8'hFF, K_INVALID, 5'd0, 1'b1}},
			'{"", 8'h80, 1, 1'b0, 1'b1, '{8'h80, K_INVALID, 5'd0, 1'b1}},
			'{"!", 8'h00, 1, 1'b0, 1'b0, NO_TOK},
			'{"a", 8'h00, 1, 1'b0, 1'b1, '{"!", K_BANG, 5'd0, 1'b1}},
			'{"==", 8'h00, 1, 1'b0, 1'b0, NO_TOK},
			'{"!=", 8'h00, 1, 1'b0, 1'b0, NO_TOK},
			'{"<=", 8'h00, 1, 1'b0, 1'b0, NO_TOK},
			'{">=", 8'h00, 1, 1'b0, 1'b0, NO_TOK},
			'{"12ab", 8'h00, 1, 1'b0, 1'b0, NO_TOK},
			'{"+-*%,;(){}", 8'h00, 1, 1'b0, 1'b0, NO_TOK},
			'{"/*/", 8'h00, 1, 1'b0, 1'b0, NO_TOK},
			'{"**/", 8'h00, 1, 1'b0, 1'b0, NO_TOK},
			'{"/3", 8'h00, 1, 1'b0, 1'b0, NO_TOK},
			'{">/", 8'h00, 1, 1'b0, 1'b0, NO_TOK},
			'{"/x", 8'h00, 1, 1'b0, 1'b0, NO_TOK},
			'{"", 8'h0A, 1, 1'b0, 1'b0, NO_TOK},
			'{"if else while return int ", 8'h00, 1, 1'b0, 1'b0, NO_TOK},
			'{"x", 8'h00, WORD_MAX, 1'b0, 1'b0, NO_TOK},
			'{"x", 8'h00, 1, 1'b0, 1'b1, '{8'h00, K_LONG, 5'd0, 1'b1}},
			'{"yz", 8'h00, 1, 1'b0, 1'b0, NO_TOK},
			'{"", 8'h00, 1, 1'b1, 1'b1, '{8'h00, K_END, 5'd0, 1'b1}},
			'{"/*", 8'h00, 1, 1'b0, 1'b0, NO_TOK},
			'{"", 8'h00, 1, 1'b1, 1'b1, '{8'h00, K_END, 5'd0, 1'b1}},
			'{"=", 8'h00, 1, 1'b0, 1'b0, NO_TOK},
			'{"", 8'h00, 1, 1'b1, 1'b0, NO_TOK},
			'{"ab_1", 8'h00, 1, 1'b0, 1'b0, NO_TOK},
			'{"", 8'h00, 1, 1'b1, 1'b0, NO_TOK},
			'{"/", 8'h00, 1, 1'b0, 1'b0, NO_TOK},
			'{"", 8'h00, 1, 1'b1, 1'b0, NO_TOK},
			'{"", 8'h7F, 1, 1'b0, 1'b1, '{8'h7F, K_INVALID, 5'd0, 1'b1}}
		};

		arst_n       = 1'b0;
		src_valid    = 1'b0;
		in_char      = '0;
		end_of_input = 1'b0;

		foreach (dir_table[r]) begin
			for (int k = 0; k < dir_table[r].reps; k++) begin
				if (dir_table[r].eoi || dir_table[r].text.len() == 0) begin
					it.ch    = dir_table[r].raw;
					it.eoi   = dir_table[r].eoi;
					it.typed = dir_table[r].typed;
					it.exp   = dir_table[r].exp;
					source_items.push_back(it);
				end else begin
					add_text(dir_table[r].text);
					// the typed result belongs to the last byte of the row
					if (dir_table[r].typed) begin
						n_last = source_items.size() - 1;
						source_items[n_last].typed = 1'b1;
						source_items[n_last].exp   = dir_table[r].exp;
					end
				end
			end
		end
		n_dir = source_items.size();
		n_counted = 0;
		while (n_counted < RANDOM_ITEMS) add_fragment();
		add_eoi();
		n_items = source_items.size();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (source_items[i]) begin
			idle_src = (i < n_items - CALM_TAIL) && ((i / 64) % 3 != 2);
			idle_rx  = idle_src;
			if (i == n_dir + 100) hold_start = 1'b1;
			if (i == n_dir + 180) begin
				// hold the source until every queued token has drained
				src_valid <= 1'b0;
				while (pending_tokens.size() != 0) @(posedge clk);
				repeat (20) @(negedge clk);
			end
			send_item(source_items[i]);
		end
		src_valid <= 1'b0;

		while (pending_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("c_subset_tokenizer_top_test OK");
		else
			$display("c_subset_tokenizer_top_test NOT OK");
		$finish;
	end

	initial begin : token_side
		int n;
		tok_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_start) begin
				// long hold-off: let the block back up into its source
				hold_start = 1'b0;
				tok_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				tok_stall <= 1'b0;
			end else if (idle_rx && $urandom_range(0, 5) == 0) begin
				tok_stall <= 1'b1;
				n = $urandom_range(1, 5);
				repeat (n) @(negedge clk);
				tok_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_tokens
		tok_t want;
		if (arst_n && tok_valid && !tok_stall) begin
			if (pending_tokens.size() == 0) begin
				report($sformatf("unexpected token item char %h kind %0d index %0d last %b",
					token_char, token_kind, char_index, last));
			end else begin
				want = pending_tokens.pop_front();
				if (token_char !== want.ch)
					report($sformatf("token_char %h, expected %h", token_char, want.ch));
				if (token_kind !== want.kind)
					report($sformatf("token_kind %0d, expected %0d", token_kind, want.kind));
				if (char_index !== want.idx)
					report($sformatf("char_index %0d, expected %0d", char_index, want.idx));
				if (last !== want.lst)
					report($sformatf("last %b, expected %b", last, want.lst));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (src_valid && !src_stall) || (tok_valid && !tok_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TIMEOUT: no handshake for %0d cycles", QUIET_LIMIT);
			$display("c_subset_tokenizer_top_test NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
